@@ hw/rtl/wsfb_pkg.sv @@
package wsfb_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0]  OPCODE_BYTE  = 8'h82;
    localparam logic [7:0]  MASK_BIT     = 8'h80;
    localparam logic [7:0]  LEN_EXT16    = 8'hFE;
    localparam logic [15:0] LEN_SHORT_MAX = 16'd126;

    localparam logic [31:0] MASK_KEY_RST      = 32'h12345678;
    localparam logic [14:0] FRAME_SAMPLES_RST = 15'd1024;

    localparam logic [1:0] CFG_MASK_KEY      = 2'd0;
    localparam logic [1:0] CFG_MUTED         = 2'd1;
    localparam logic [1:0] CFG_FRAME_SAMPLES = 2'd2;

    typedef struct packed {
        logic [7:0]  pay_lo;
        logic [7:0]  pay_hi;
        logic        hdr;
        logic        long_len;
        logic        last;
        logic [15:0] len;
        logic [31:0] key;
    } wsfb_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OP,
        ST_LEN,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_P0,
        ST_P1
    } wsfb_step_t;

endpackage

@@ hw/rtl/wsfb_front.sv @@
module wsfb_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [15:0]             sample,
    input  logic                    cfg_valid,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    input  logic                    q_full,
    output logic                    q_wr,
    output wsfb_pkg::wsfb_cmd_t     q_cmd
);

    logic [31:0] mask_key_reg;
    logic        muted_reg;
    logic [14:0] frame_samples_reg;
    logic [14:0] sample_position_reg;
    logic [14:0] sample_position_next;

    logic [14:0] fs;
    logic [15:0] len;
    logic        last;
    logic [7:0]  m0;
    logic [7:0]  m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_key_reg      <= wsfb_pkg::MASK_KEY_RST;
            muted_reg         <= 1'b1;
            frame_samples_reg <= wsfb_pkg::FRAME_SAMPLES_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wsfb_pkg::CFG_MASK_KEY:      mask_key_reg      <= cfg_data;
                wsfb_pkg::CFG_MUTED:         muted_reg         <= cfg_data[0];
                wsfb_pkg::CFG_FRAME_SAMPLES: frame_samples_reg <= cfg_data[14:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        fs   = (frame_samples_reg == 15'd0) ? 15'd1 : frame_samples_reg;
        len  = {fs, 1'b0};
        last = (({1'b0, sample_position_reg} + 16'd1) >= {1'b0, fs});
        m0   = sample_position_reg[0] ? mask_key_reg[15:8] : mask_key_reg[31:24];
        m1   = sample_position_reg[0] ? mask_key_reg[7:0]  : mask_key_reg[23:16];

        q_wr              = push && !q_full && !muted_reg;
        q_cmd.pay_lo      = sample[7:0] ^ m0;
        q_cmd.pay_hi      = sample[15:8] ^ m1;
        q_cmd.hdr         = (sample_position_reg == 15'd0);
        q_cmd.long_len    = (len >= wsfb_pkg::LEN_SHORT_MAX);
        q_cmd.last        = last;
        q_cmd.len         = len;
        q_cmd.key         = mask_key_reg;

        sample_position_next = last ? 15'd0 : sample_position_reg + 15'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_position_reg <= 15'd0;
        end
        else if (q_wr)
        begin
            sample_position_reg <= sample_position_next;
        end
    end

endmodule

@@ hw/rtl/wsfb_queue.sv @@
module wsfb_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  wsfb_pkg::wsfb_cmd_t     wr_cmd,
    input  logic                    rd_en,
    output wsfb_pkg::wsfb_cmd_t     rd_cmd,
    output logic                    rd_valid,
    output logic                    full
);

    wsfb_pkg::wsfb_cmd_t          entry_reg [wsfb_pkg::QDEPTH];
    logic [wsfb_pkg::QAW-1:0]     wr_ptr_reg;
    logic [wsfb_pkg::QAW-1:0]     rd_ptr_reg;
    logic [wsfb_pkg::QAW:0]       count_reg;
    logic [wsfb_pkg::QAW:0]       count_next;

    always_comb
    begin
        rd_cmd     = entry_reg[rd_ptr_reg];
        rd_valid   = (count_reg != '0);
        full       = (count_reg == (wsfb_pkg::QAW+1)'(wsfb_pkg::QDEPTH));
        count_next = count_reg;
        if (wr_en && !(rd_en && rd_valid))
        begin
            count_next = count_reg + (wsfb_pkg::QAW+1)'(1);
        end
        else if (!wr_en && rd_en && rd_valid)
        begin
            count_next = count_reg - (wsfb_pkg::QAW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + (wsfb_pkg::QAW)'(1);
            end
            if (rd_en && rd_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + (wsfb_pkg::QAW)'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("queue written while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (wsfb_pkg::QAW+1)'(wsfb_pkg::QDEPTH))
        else $error("queue count overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");

endmodule

@@ hw/rtl/wsfb_back.sv @@
module wsfb_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  wsfb_pkg::wsfb_cmd_t     cmd,
    input  logic                    cmd_valid,
    output logic                    cmd_pop,
    input  logic                    pop,
    output logic                    empty,
    output logic [7:0]              out_byte,
    output logic                    frame_end,
    output logic                    item_last
);

    wsfb_pkg::wsfb_step_t step_reg;
    wsfb_pkg::wsfb_step_t step_next;
    wsfb_pkg::wsfb_step_t cur;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       frame_end_reg;
    logic       item_last_reg;
    logic       advance;
    logic [7:0] byte_next;
    logic       fend_next;
    logic       ilast_next;

    always_comb
    begin
        if (step_reg == wsfb_pkg::ST_IDLE)
        begin
            cur = cmd.hdr ? wsfb_pkg::ST_OP : wsfb_pkg::ST_P0;
        end
        else
        begin
            cur = step_reg;
        end

        advance    = cmd_valid && (!out_valid_reg || pop);
        byte_next  = cmd.pay_lo;
        fend_next  = 1'b0;
        ilast_next = 1'b0;
        step_next  = step_reg;

        case (cur)
            wsfb_pkg::ST_OP:
            begin
                byte_next = wsfb_pkg::OPCODE_BYTE;
                step_next = wsfb_pkg::ST_LEN;
            end
            wsfb_pkg::ST_LEN:
            begin
                byte_next = cmd.long_len ? wsfb_pkg::LEN_EXT16
                                         : (wsfb_pkg::MASK_BIT | cmd.len[7:0]);
                step_next = cmd.long_len ? wsfb_pkg::ST_LEN_HI : wsfb_pkg::ST_K0;
            end
            wsfb_pkg::ST_LEN_HI:
            begin
                byte_next = cmd.len[15:8];
                step_next = wsfb_pkg::ST_LEN_LO;
            end
            wsfb_pkg::ST_LEN_LO:
            begin
                byte_next = cmd.len[7:0];
                step_next = wsfb_pkg::ST_K0;
            end
            wsfb_pkg::ST_K0:
            begin
                byte_next = cmd.key[31:24];
                step_next = wsfb_pkg::ST_K1;
            end
            wsfb_pkg::ST_K1:
            begin
                byte_next = cmd.key[23:16];
                step_next = wsfb_pkg::ST_K2;
            end
            wsfb_pkg::ST_K2:
            begin
                byte_next = cmd.key[15:8];
                step_next = wsfb_pkg::ST_K3;
            end
            wsfb_pkg::ST_K3:
            begin
                byte_next = cmd.key[7:0];
                step_next = wsfb_pkg::ST_P0;
            end
            wsfb_pkg::ST_P0:
            begin
                byte_next = cmd.pay_lo;
                step_next = wsfb_pkg::ST_P1;
            end
            wsfb_pkg::ST_P1:
            begin
                byte_next  = cmd.pay_hi;
                fend_next  = cmd.last;
                ilast_next = 1'b1;
                step_next  = wsfb_pkg::ST_IDLE;
            end
            default:
            begin
                step_next = wsfb_pkg::ST_IDLE;
            end
        endcase

        cmd_pop   = advance && (cur == wsfb_pkg::ST_P1);
        empty     = !out_valid_reg;
        out_byte  = out_byte_reg;
        frame_end = frame_end_reg;
        item_last = item_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= wsfb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                step_reg      <= step_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg  <= byte_next;
            frame_end_reg <= fend_next;
            item_last_reg <= ilast_next;
        end
    end

    a_op_then_len: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cur == wsfb_pkg::ST_OP) |=> (step_reg == wsfb_pkg::ST_LEN))
        else $error("length byte does not follow opcode");

    a_fend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_end_reg) |-> item_last_reg)
        else $error("frame end on a byte that is not the last of a sample");

    a_pop_after_p1: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (step_reg == wsfb_pkg::ST_IDLE && item_last_reg))
        else $error("command released before its last byte");

endmodule

@@ hw/rtl/websocket_masked_frame_builder.sv @@
// Builds masked binary client frames from 16-bit audio samples, one byte per result word.
// The first sample of a frame produces the opcode byte, the length byte (plus two extended
// length bytes when the payload is 126 bytes or more) and the four mask-key bytes ahead of
// its two payload bytes; every other sample produces two masked payload bytes, low byte
// first. The byte-wide output register sets the pace: a sample yields 2 bytes, a
// frame-opening sample 8 or 10. A four-entry command queue between the sample side and
// the byte sequencer absorbs the header burst, so samples keep flowing while earlier
// bytes drain. While muted, samples are taken and dropped. Configuration writes are
// always ready and must only occur while the block is idle.
module websocket_masked_frame_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] sample,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic        item_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    wsfb_pkg::wsfb_cmd_t wr_cmd;
    wsfb_pkg::wsfb_cmd_t rd_cmd;
    logic                q_wr;
    logic                q_rd;
    logic                q_valid;
    logic                q_full;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    wsfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_cmd     (wr_cmd)
    );

    wsfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_cmd   (wr_cmd),
        .rd_en    (q_rd),
        .rd_cmd   (rd_cmd),
        .rd_valid (q_valid),
        .full     (q_full)
    );

    wsfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (rd_cmd),
        .cmd_valid (q_valid),
        .cmd_pop   (q_rd),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .frame_end (frame_end),
        .item_last (item_last)
    );

endmodule
